### rtl/core/glt_pkg.sv
// types, codes and character constants for the gate language tokenizer
// shared by gate_language_tokenizer; no dependencies
package glt_pkg;

    // token kinds seen on the result channel
    localparam logic [3:0] K_IDENT   = 4'd0;
    localparam logic [3:0] K_NUMBER  = 4'd1;
    localparam logic [3:0] K_CHIP    = 4'd2;
    localparam logic [3:0] K_LPAREN  = 4'd3;
    localparam logic [3:0] K_RPAREN  = 4'd4;
    localparam logic [3:0] K_LBRACE  = 4'd5;
    localparam logic [3:0] K_RBRACE  = 4'd6;
    localparam logic [3:0] K_LBRACK  = 4'd7;
    localparam logic [3:0] K_RBRACK  = 4'd8;
    localparam logic [3:0] K_COMMA   = 4'd9;
    localparam logic [3:0] K_SEMI    = 4'd10;
    localparam logic [3:0] K_EQUALS  = 4'd11;
    localparam logic [3:0] K_ARROW   = 4'd12;
    localparam logic [3:0] K_END     = 4'd13;
    localparam logic [3:0] K_ERROR   = 4'd14;

    // internal item kinds, wider so comment marks never reach the output
    localparam logic [4:0] R_LINE_START  = 5'd16;
    localparam logic [4:0] R_BLOCK_START = 5'd17;
    localparam logic [4:0] R_BLOCK_END   = 5'd18;
    localparam logic [4:0] R_NEWLINE     = 5'd19;

    // error codes
    localparam logic [1:0] E_NONE     = 2'd0;
    localparam logic [1:0] E_STRAY    = 2'd1;
    localparam logic [1:0] E_TOO_LONG = 2'd2;
    localparam logic [1:0] E_OPEN_END = 2'd3;

    // scan modes
    localparam logic [1:0] M_IDLE   = 2'd0;
    localparam logic [1:0] M_IDENT  = 2'd1;
    localparam logic [1:0] M_NUMBER = 2'd2;
    localparam logic [1:0] M_SKIP   = 2'd3;

    // held first character of a two-character token
    localparam logic [1:0] H_NONE  = 2'd0;
    localparam logic [1:0] H_SLASH = 2'd1;
    localparam logic [1:0] H_STAR  = 2'd2;
    localparam logic [1:0] H_DASH  = 2'd3;

    // keyword match progress
    localparam logic [2:0] KW_DONE = 3'd4;
    localparam logic [2:0] KW_FAIL = 3'd7;

    // characters
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_C      = 8'h63;
    localparam logic [7:0] CH_H      = 8'h68;
    localparam logic [7:0] CH_I      = 8'h69;
    localparam logic [7:0] CH_P      = 8'h70;

    localparam logic [15:0] LEN_MAX  = 16'hFFFF;
    localparam logic [15:0] LINE_MAX = 16'hFFFF;

    // one result item
    typedef struct packed {
        logic        last;
        logic [1:0]  err;
        logic [15:0] line;
        logic [29:0] val;
        logic [15:0] len;
        logic [15:0] start;
        logic [3:0]  kind;
    } token_t;

    // results and comment flags gathered while one byte is processed
    typedef struct packed {
        logic             lc;
        logic             bc;
        logic [1:0]       n;
        logic [15:0]      line;
        token_t [2:0]     res;
    } ctx_t;

    function automatic logic is_digit(logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic is_ender(logic [7:0] b);
        logic r;
        unique case (b)
            CH_SPACE, CH_TAB, CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE,
            CH_LBRACK, CH_RBRACK, CH_DASH, CH_GT, CH_EQUALS, CH_SEMI,
            CH_COMMA, CH_NL, CH_STAR, CH_SLASH: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] kw_char(logic [1:0] idx);
        logic [7:0] r;
        unique case (idx)
            2'd0: r = CH_C;
            2'd1: r = CH_H;
            2'd2: r = CH_I;
            default: r = CH_P;
        endcase
        return r;
    endfunction

    // append a result unless three are already gathered
    function automatic ctx_t push(ctx_t c, logic [3:0] kind, logic [15:0] st,
                                  logic [15:0] len, logic [29:0] val, logic [1:0] err);
        token_t t;
        t = '{last: 1'b0, err: err, line: c.line, val: val, len: len,
              start: st, kind: kind};
        if (c.n != 2'd3) begin
            c.res[c.n] = t;
            c.n = c.n + 2'd1;
        end
        return c;
    endfunction

    // update comment flags, then emit the item if no comment hides it
    function automatic ctx_t deliver(ctx_t c, logic [4:0] kind, logic [15:0] st,
                                     logic [15:0] len, logic [29:0] val, logic [1:0] err);
        if (c.lc && kind == R_NEWLINE) begin
            c.lc = 1'b0;
        end else if (c.bc && kind == R_BLOCK_END) begin
            c.bc = 1'b0;
        end else if (kind == R_LINE_START) begin
            c.lc = 1'b1;
        end else if (kind == R_BLOCK_START) begin
            c.bc = 1'b1;
        end
        if (!(c.lc || c.bc || kind == R_BLOCK_END || kind == R_NEWLINE)) begin
            c = push(c, kind[3:0], st, len, val, err);
        end
        return c;
    endfunction

endpackage

### rtl/core/gate_language_tokenizer.sv
// gate_language_tokenizer: byte stream in, tokens of the gate language out
// uses glt_pkg for token types, codes and the comment and emit helpers
//
// the first token of a byte is on m_tdata in the cycle after the byte is taken
// throughput: one byte per cycle while each byte yields at most one token and
//   m_tready is high; a byte that yields more (up to three) holds the input
//   while the three-entry result buffer drains, one token per m_tready cycle
// reset: synchronous, active low; clears scan state, counters and the buffer count
module gate_language_tokenizer
    import glt_pkg::*;
#(
    parameter int unsigned MAX_SOURCE_BYTES = 65536,
    parameter int unsigned MAX_DIGITS       = 9
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // [3:0] token_kind, [19:4] token_start,
                                   // [35:20] token_length, [65:36] number_value,
                                   // [81:66] line_index, [83:82] error_code,
                                   // [87:84] zero
    output logic        m_tlast    // run_last
);

    localparam int unsigned OFFSET_CAP_I =
        (MAX_SOURCE_BYTES - 1) < 65535 ? (MAX_SOURCE_BYTES - 1) : 65535;
    localparam logic [15:0] OFFSET_CAP = OFFSET_CAP_I[15:0];
    localparam logic [3:0]  DIGIT_MAX  = MAX_DIGITS[3:0];

    // scan state
    logic [1:0]  mode_reg,  mode_next;
    logic [1:0]  held_reg,  held_next;
    logic [15:0] start_reg, start_next;
    logic [15:0] boff_reg,  boff_next;
    logic [15:0] run_reg,   run_next;
    logic [29:0] acc_reg,   acc_next;
    logic [3:0]  dcnt_reg,  dcnt_next;
    logic [2:0]  kw_reg,    kw_next;
    logic        lc_reg,    bc_reg;
    logic [15:0] line_reg;

    // result buffer
    token_t [2:0] slot_reg;
    logic [1:0]   pend_reg;
    logic [1:0]   rd_reg;

    ctx_t        c;
    token_t      cur;
    logic        s_accept;
    logic        m_accept;
    logic [7:0]  b;
    logic [29:0] acc_x10;

    assign b        = s_tdata;
    assign s_accept = s_tvalid && s_tready;
    assign m_accept = m_tvalid && m_tready;
    assign acc_x10  = (acc_reg << 3) + (acc_reg << 1);

    // one byte through the scanner
    always_comb begin
        logic do_start;
        c          = '{lc: lc_reg, bc: bc_reg, n: 2'd0, line: line_reg, res: '0};
        mode_next  = mode_reg;
        held_next  = held_reg;
        start_next = start_reg;
        boff_next  = boff_reg;
        run_next   = run_reg;
        acc_next   = acc_reg;
        dcnt_next  = dcnt_reg;
        kw_next    = kw_reg;
        do_start   = 1'b0;

        // finish what the previous bytes left open
        if (held_reg != H_NONE) begin
            held_next = H_NONE;
            if (held_reg == H_SLASH && b == CH_SLASH) begin
                c = deliver(c, R_LINE_START, start_reg, 16'd2, '0, E_NONE);
            end else if (held_reg == H_SLASH && b == CH_STAR) begin
                c = deliver(c, R_BLOCK_START, start_reg, 16'd2, '0, E_NONE);
            end else if (held_reg == H_STAR && b == CH_SLASH) begin
                c = deliver(c, R_BLOCK_END, start_reg, 16'd2, '0, E_NONE);
            end else if (held_reg == H_DASH && b == CH_GT) begin
                c = deliver(c, {1'b0, K_ARROW}, start_reg, 16'd2, '0, E_NONE);
            end else begin
                c = deliver(c, {1'b0, K_ERROR}, start_reg, 16'd1, '0, E_STRAY);
                do_start = 1'b1;
            end
        end else if (mode_reg == M_IDENT) begin
            if (is_ender(b)) begin
                mode_next = M_IDLE;
                c = deliver(c, {1'b0, K_IDENT}, start_reg, run_reg, '0, E_NONE);
                do_start = 1'b1;
            end else begin
                if (run_reg != LEN_MAX) begin
                    run_next = run_reg + 16'd1;
                end
                if (kw_reg < KW_DONE && b == kw_char(kw_reg[1:0])) begin
                    kw_next = kw_reg + 3'd1;
                    if (kw_next == KW_DONE) begin
                        mode_next = M_IDLE;
                        c = deliver(c, {1'b0, K_CHIP}, start_reg, 16'd4, '0, E_NONE);
                    end
                end else begin
                    kw_next = KW_FAIL;
                end
            end
        end else if (mode_reg == M_NUMBER) begin
            if (is_digit(b)) begin
                if (dcnt_reg >= DIGIT_MAX) begin
                    mode_next = M_SKIP;
                    c = deliver(c, {1'b0, K_ERROR}, start_reg,
                                {12'd0, dcnt_reg} + 16'd1, '0, E_TOO_LONG);
                end else begin
                    acc_next  = acc_x10 + {26'd0, b[3:0]};
                    dcnt_next = dcnt_reg + 4'd1;
                    run_next  = run_reg + 16'd1;
                end
            end else begin
                mode_next = M_IDLE;
                c = deliver(c, {1'b0, K_NUMBER}, start_reg, run_reg, acc_reg, E_NONE);
                do_start = 1'b1;
            end
        end else if (mode_reg == M_SKIP) begin
            if (!is_digit(b)) begin
                mode_next = M_IDLE;
                do_start  = 1'b1;
            end
        end else begin
            do_start = 1'b1;
        end

        // this byte opens something new
        if (do_start) begin
            unique case (b)
                CH_SPACE, CH_TAB: ;
                CH_LPAREN: c = deliver(c, {1'b0, K_LPAREN}, boff_reg, 16'd1, '0, E_NONE);
                CH_RPAREN: c = deliver(c, {1'b0, K_RPAREN}, boff_reg, 16'd1, '0, E_NONE);
                CH_LBRACE: c = deliver(c, {1'b0, K_LBRACE}, boff_reg, 16'd1, '0, E_NONE);
                CH_RBRACE: c = deliver(c, {1'b0, K_RBRACE}, boff_reg, 16'd1, '0, E_NONE);
                CH_LBRACK: c = deliver(c, {1'b0, K_LBRACK}, boff_reg, 16'd1, '0, E_NONE);
                CH_RBRACK: c = deliver(c, {1'b0, K_RBRACK}, boff_reg, 16'd1, '0, E_NONE);
                CH_COMMA:  c = deliver(c, {1'b0, K_COMMA},  boff_reg, 16'd1, '0, E_NONE);
                CH_SEMI:   c = deliver(c, {1'b0, K_SEMI},   boff_reg, 16'd1, '0, E_NONE);
                CH_EQUALS: c = deliver(c, {1'b0, K_EQUALS}, boff_reg, 16'd1, '0, E_NONE);
                CH_NL: begin
                    c = deliver(c, R_NEWLINE, boff_reg, 16'd1, '0, E_NONE);
                    if (c.line != LINE_MAX) begin
                        c.line = c.line + 16'd1;
                    end
                end
                CH_SLASH: begin
                    held_next  = H_SLASH;
                    start_next = boff_reg;
                end
                CH_STAR: begin
                    held_next  = H_STAR;
                    start_next = boff_reg;
                end
                CH_DASH: begin
                    held_next  = H_DASH;
                    start_next = boff_reg;
                end
                CH_GT: c = deliver(c, {1'b0, K_ERROR}, boff_reg, 16'd1, '0, E_STRAY);
                default: begin
                    start_next = boff_reg;
                    run_next   = 16'd1;
                    if (is_digit(b)) begin
                        mode_next = M_NUMBER;
                        acc_next  = {26'd0, b[3:0]};
                        dcnt_next = 4'd1;
                    end else begin
                        mode_next = M_IDENT;
                        kw_next   = (b == CH_C) ? 3'd1 : KW_FAIL;
                    end
                end
            endcase
        end

        if (boff_reg < OFFSET_CAP) begin
            boff_next = boff_reg + 16'd1;
        end

        // end of source: report an open token as an error, end token, back to reset
        if (s_tlast) begin
            if (held_next != H_NONE) begin
                c = deliver(c, {1'b0, K_ERROR}, start_next, 16'd1, '0, E_STRAY);
            end else if (mode_next == M_IDENT || mode_next == M_NUMBER) begin
                c = deliver(c, {1'b0, K_ERROR}, start_next, run_next, '0, E_OPEN_END);
            end
            c = push(c, K_END, boff_next, 16'd0, '0, E_NONE);
            mode_next  = M_IDLE;
            held_next  = H_NONE;
            start_next = '0;
            boff_next  = '0;
            run_next   = '0;
            acc_next   = '0;
            dcnt_next  = '0;
            kw_next    = '0;
            c.lc       = 1'b0;
            c.bc       = 1'b0;
            c.line     = '0;
        end

        // mark the last result of this byte
        if (c.n != 2'd0) begin
            c.res[c.n - 2'd1].last = 1'b1;
        end
    end

    // scan state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= M_IDLE;
            held_reg  <= H_NONE;
            start_reg <= '0;
            boff_reg  <= '0;
            run_reg   <= '0;
            acc_reg   <= '0;
            dcnt_reg  <= '0;
            kw_reg    <= '0;
            lc_reg    <= 1'b0;
            bc_reg    <= 1'b0;
            line_reg  <= '0;
        end else if (s_accept) begin
            mode_reg  <= mode_next;
            held_reg  <= held_next;
            start_reg <= start_next;
            boff_reg  <= boff_next;
            run_reg   <= run_next;
            acc_reg   <= acc_next;
            dcnt_reg  <= dcnt_next;
            kw_reg    <= kw_next;
            lc_reg    <= c.lc;
            bc_reg    <= c.bc;
            line_reg  <= c.line;
        end
    end

    // result buffer control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 2'd0;
            rd_reg   <= 2'd0;
        end else if (s_accept) begin
            pend_reg <= c.n;
            rd_reg   <= 2'd0;
        end else if (m_accept) begin
            pend_reg <= pend_reg - 2'd1;
            rd_reg   <= rd_reg + 2'd1;
        end
    end

    // result buffer payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            slot_reg <= c.res;
        end
    end

    // input taken once the buffer empties in this cycle
    assign s_tready = (pend_reg == 2'd0) || (pend_reg == 2'd1 && m_tready);

    assign cur      = slot_reg[rd_reg];
    assign m_tvalid = (pend_reg != 2'd0);
    assign m_tdata  = {4'd0, cur.err, cur.line, cur.val, cur.len, cur.start, cur.kind};
    assign m_tlast  = cur.last;

    // buffer read pointer never passes the filled slots
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ({1'b0, rd_reg} + {1'b0, pend_reg}) <= 3'd3)
        else $error("result buffer pointer out of range");

    // the final result of a request carries tlast
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_accept && pend_reg == 2'd1 |-> m_tlast)
        else $error("last result of a request without tlast");

    // end token always closes its run
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && cur.kind == K_END |-> m_tlast)
        else $error("end token not last");

    // error code set exactly on error tokens
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((cur.kind == K_ERROR) == (cur.err != E_NONE)))
        else $error("error code does not match token kind");

    // end of source returns scan state to reset
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tlast |=> mode_reg == M_IDLE && held_reg == H_NONE &&
                                boff_reg == 16'd0 && line_reg == 16'd0 &&
                                !lc_reg && !bc_reg)
        else $error("state not cleared after end of source");

endmodule
